>>> design/ccpd_pkg.sv
// shared types, widths and register codes for the cruise control pd throttle block
package ccpd_pkg;

  // field widths
  localparam int VEL_W      = 16;
  localparam int THR_W      = 8;
  localparam int GAIN_W     = 8;
  localparam int LIM_W      = 15;
  localparam int ERR_W      = VEL_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  // kp*e + kd*de stays below 2^26 in magnitude
  localparam int CORR_W     = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [GAIN_W-1:0]       GAIN_P_RST = 8'd2;
  localparam logic [GAIN_W-1:0]       GAIN_D_RST = 8'd0;
  localparam logic [LIM_W-1:0]        LIMIT_RST  = 15'd80;
  localparam logic [THR_W-1:0]        FULL_RST   = 8'd80;
  localparam logic [THR_W-1:0]        IDLE_RST   = 8'd10;
  localparam logic signed [VEL_W-1:0] ENGAGE_RST = 16'sd25;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P = 3'd0,
    REG_GAIN_D = 3'd1,
    REG_LIMIT  = 3'd2,
    REG_FULL   = 3'd3,
    REG_IDLE   = 3'd4,
    REG_ENGAGE = 3'd5
  } ccpd_reg_t;

  // input item of one control tick
  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    logic                    engine_on;
    logic                    high_gear;
    logic                    cruise_request;
    logic                    accel_pedal;
  } ccpd_in_t;

  // result item
  typedef struct packed {
    logic [THR_W-1:0]        throttle;
    logic                    cruise_active;
    logic signed [VEL_W-1:0] shown_target;
  } ccpd_out_t;

  // configuration write transaction
  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } ccpd_cfg_wr_t;

  // configuration register contents
  typedef struct packed {
    logic [GAIN_W-1:0]       gain_proportional;
    logic [GAIN_W-1:0]       gain_derivative;
    logic [LIM_W-1:0]        correction_limit;
    logic [THR_W-1:0]        full_throttle;
    logic [THR_W-1:0]        idle_throttle;
    logic signed [VEL_W-1:0] engage_speed;
  } ccpd_cfg_t;

  // controller state carried from tick to tick
  typedef struct packed {
    logic [THR_W-1:0]        held_throttle;
    logic                    target_latched;
    logic signed [VEL_W-1:0] target_speed;
    logic signed [ERR_W-1:0] previous_error;
  } ccpd_state_t;

endpackage

>>> design/ccpd_stream_if.sv
// valid/ready channel carrying one payload per transaction
interface ccpd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/ccpd_cfg_regs.sv
// configuration register file of the cruise control pd throttle block
module ccpd_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  ccpd_pkg::ccpd_cfg_wr_t wr,
  output ccpd_pkg::ccpd_cfg_t   regs
);
  import ccpd_pkg::*;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_proportional <= GAIN_P_RST;
      regs.gain_derivative   <= GAIN_D_RST;
      regs.correction_limit  <= LIMIT_RST;
      regs.full_throttle     <= FULL_RST;
      regs.idle_throttle     <= IDLE_RST;
      regs.engage_speed      <= ENGAGE_RST;
    end else if (wr_en) begin
      unique case (ccpd_reg_t'(wr.index))
        REG_GAIN_P: regs.gain_proportional <= wr.value[GAIN_W-1:0];
        REG_GAIN_D: regs.gain_derivative   <= wr.value[GAIN_W-1:0];
        REG_LIMIT:  regs.correction_limit  <= wr.value[LIM_W-1:0];
        REG_FULL:   regs.full_throttle     <= wr.value[THR_W-1:0];
        REG_IDLE:   regs.idle_throttle     <= wr.value[THR_W-1:0];
        REG_ENGAGE: regs.engage_speed      <= $signed(wr.value[VEL_W-1:0]);
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/ccpd_step.sv
// one control tick: engagement, pd correction with clamp, throttle update
module ccpd_step (
  input  ccpd_pkg::ccpd_cfg_t   regs,
  input  ccpd_pkg::ccpd_state_t state,
  input  ccpd_pkg::ccpd_in_t    item,
  output ccpd_pkg::ccpd_state_t state_next,
  output ccpd_pkg::ccpd_out_t   res
);
  import ccpd_pkg::*;

  logic                     active;
  logic signed [VEL_W-1:0]  target;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [CORR_W-1:0] p_term;
  logic signed [CORR_W-1:0] d_term;
  logic signed [CORR_W-1:0] corr_raw;
  logic signed [CORR_W-1:0] lim_pos;
  logic signed [CORR_W-1:0] lim_neg;
  logic signed [CORR_W-1:0] corr;
  logic [THR_W-1:0]         base_throttle;
  logic [THR_W-1:0]         throttle;

  // regulation runs in high gear with cruise requested at or above engage speed
  assign active = item.engine_on & item.high_gear & item.cruise_request &
                  ($signed(item.velocity) >= $signed(regs.engage_speed));

  // target latches on the first regulating tick
  assign target = state.target_latched ? state.target_speed : item.velocity;

  // exact error and change in error
  assign err  = $signed({target[VEL_W-1], target}) -
                $signed({item.velocity[VEL_W-1], item.velocity});
  assign diff = $signed({err[ERR_W-1], err}) -
                $signed({state.previous_error[ERR_W-1], state.previous_error});

  // pd products, gains are unsigned
  assign p_term = $signed({{(CORR_W-GAIN_W){1'b0}}, regs.gain_proportional}) *
                  $signed({{(CORR_W-ERR_W){err[ERR_W-1]}}, err});
  assign d_term = $signed({{(CORR_W-GAIN_W){1'b0}}, regs.gain_derivative}) *
                  $signed({{(CORR_W-DIFF_W){diff[DIFF_W-1]}}, diff});
  assign corr_raw = p_term + d_term;

  // symmetric clamp
  assign lim_pos = $signed({{(CORR_W-LIM_W){1'b0}}, regs.correction_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (corr_raw > lim_pos) begin
      corr = lim_pos;
    end else if (corr_raw < lim_neg) begin
      corr = lim_neg;
    end else begin
      corr = corr_raw;
    end
  end

  // accelerator overrides the held value before regulation
  assign base_throttle = item.accel_pedal ? regs.full_throttle : state.held_throttle;

  // throttle and state update
  always_comb begin
    state_next = state;
    throttle   = state.held_throttle;
    if (item.engine_on) begin
      if (active) begin
        throttle                  = base_throttle + corr[THR_W-1:0];
        state_next.target_latched = 1'b1;
        state_next.target_speed   = target;
        state_next.previous_error = err;
      end else begin
        // dropping a latched target or releasing the pedal falls back to idle
        throttle = (state.target_latched || !item.accel_pedal) ?
                   regs.idle_throttle : regs.full_throttle;
        state_next.target_latched = 1'b0;
      end
      state_next.held_throttle = throttle;
    end
  end

  // result item
  assign res.throttle      = throttle;
  assign res.cruise_active = active;
  assign res.shown_target  = active ? target : '0;

endmodule

>>> design/cruise_control_pd_throttle.sv
// top level of the cruise control pd throttle regulator
//
//   channel  | dir | payload                                          | handshake
//   cfg      | in  | index, value (register write)                    | valid/ready
//   sample   | in  | velocity, engine_on, high_gear, cruise_request,  | valid/ready
//            |     | accel_pedal                                      |
//   result   | out | throttle, cruise_active, shown_target            | valid/ready
//
// one item per cycle sustained while results are taken; a result is registered
// after its sample transaction (the sample lands in the input register, the pd
// update moves it into the result register once that register is free).
// the tick state updates as an item moves into the result register, so the
// next item sees it at once. reset restores register defaults and clears state.
// a stalled result holds the pipe; sample stays ready while the input stage is
// free or moving. cfg is always ready.
module cruise_control_pd_throttle (
  input logic          clk,
  input logic          rst,
  ccpd_stream_if.sink   cfg,
  ccpd_stream_if.sink   sample,
  ccpd_stream_if.source result
);
  import ccpd_pkg::*;

  ccpd_cfg_t   regs;
  ccpd_state_t state;
  ccpd_state_t state_next;
  ccpd_in_t    s1_item;
  ccpd_out_t   step_res;
  ccpd_out_t   out_data;
  logic        s1_valid;
  logic        out_valid;
  logic        advance;

  // configuration registers
  assign cfg.ready = 1'b1;

  ccpd_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg.valid & cfg.ready),
    .wr    (cfg.data),
    .regs  (regs)
  );

  // pipeline flow control
  assign advance      = s1_valid && (!out_valid || result.ready);
  assign sample.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_item <= sample.data;
    end
  end

  // tick update
  ccpd_step u_step (
    .regs       (regs),
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .res        (step_res)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_res;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // an inactive result never shows a target
  a_target_hidden: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.cruise_active) |-> (out_data.shown_target == '0))
    else $error("shown_target nonzero without cruise");

  // the latch is only set by a regulating tick moving through
  a_latch_source: assert property (@(posedge clk) disable iff (rst)
    $rose(state.target_latched) |-> $past(advance && step_res.cruise_active))
    else $error("target latched without a regulating tick");

  // state holds while no item moves into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an item");

  // engine off leaves the throttle alone
  a_engine_off: assert property (@(posedge clk) disable iff (rst)
    (advance && !s1_item.engine_on) |=> $stable(state.held_throttle))
    else $error("throttle changed with engine off");

endmodule

>>> test/ccpd_throttle_checker.sv
// checker for the cruise control pd throttle block: predicts each tick and compares results
`timescale 1ns / 1ps

module ccpd_throttle_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  ccpd_pkg::ccpd_cfg_wr_t cfg_data,
  input  logic                   sample_valid,
  input  logic                   sample_ready,
  input  ccpd_pkg::ccpd_in_t     sample_data,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  ccpd_pkg::ccpd_out_t    result_data,
  output int                     outstanding,
  output int                     checked,
  output int                     failures
);
  import ccpd_pkg::*;

  // mirrored register contents and controller state
  ccpd_cfg_t   settings;
  ccpd_state_t ctl;
  // predicted results still waiting for their transaction
  ccpd_out_t   due_outputs[$];

  // one control tick of the regulator, updating the mirrored state
  function automatic ccpd_out_t regulate_tick(input ccpd_in_t tick);
    ccpd_out_t res;
    logic      active;
    longint    vel;
    longint    err;
    longint    corr;
    longint    lim;
    res = '0;
    active = 1'b0;
    vel = tick.velocity;
    if (tick.engine_on) begin
      if (tick.accel_pedal) ctl.held_throttle = settings.full_throttle;
      active = tick.high_gear && tick.cruise_request &&
               (vel >= longint'(settings.engage_speed));
      if (active) begin
        // first regulating tick latches the current velocity
        if (!ctl.target_latched) begin
          ctl.target_speed = tick.velocity;
          ctl.target_latched = 1'b1;
        end
        err = longint'(ctl.target_speed) - vel;
        corr = longint'(settings.gain_proportional) * err +
               longint'(settings.gain_derivative) * (err - longint'(ctl.previous_error));
        lim = longint'(settings.correction_limit);
        if (corr > lim) corr = lim;
        if (corr < -lim) corr = -lim;
        ctl.previous_error = err[ERR_W-1:0];
        ctl.held_throttle = ctl.held_throttle + corr[THR_W-1:0];
      end else begin
        // dropping a latched target forces idle, pedal or not
        if (ctl.target_latched) ctl.held_throttle = settings.idle_throttle;
        ctl.target_latched = 1'b0;
        if (!tick.accel_pedal) ctl.held_throttle = settings.idle_throttle;
      end
    end
    res.throttle = ctl.held_throttle;
    res.cruise_active = active;
    res.shown_target = active ? ctl.target_speed : '0;
    return res;
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    ccpd_out_t want;
    if (rst) begin
      settings.gain_proportional = GAIN_P_RST;
      settings.gain_derivative = GAIN_D_RST;
      settings.correction_limit = LIMIT_RST;
      settings.full_throttle = FULL_RST;
      settings.idle_throttle = IDLE_RST;
      settings.engage_speed = ENGAGE_RST;
      ctl = '0;
      due_outputs.delete();
      outstanding = 0;
      checked = 0;
      failures = 0;
    end else begin
      // result transaction against the oldest prediction
      if (result_valid && result_ready) begin
        if (due_outputs.size() == 0) begin
          $error("result transaction with no prediction waiting");
          failures++;
        end else begin
          want = due_outputs.pop_front();
          checked++;
          if (result_data.throttle !== want.throttle) begin
            $error("throttle: expected %0d, got %0d", want.throttle, result_data.throttle);
            failures++;
          end
          if (result_data.cruise_active !== want.cruise_active) begin
            $error("cruise_active: expected %0d, got %0d",
                   want.cruise_active, result_data.cruise_active);
            failures++;
          end
          if (result_data.shown_target !== want.shown_target) begin
            $error("shown_target: expected %0d, got %0d",
                   $signed(want.shown_target), $signed(result_data.shown_target));
            failures++;
          end
        end
      end
      // register write, unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_GAIN_P: settings.gain_proportional = cfg_data.value[GAIN_W-1:0];
          REG_GAIN_D: settings.gain_derivative = cfg_data.value[GAIN_W-1:0];
          REG_LIMIT:  settings.correction_limit = cfg_data.value[LIM_W-1:0];
          REG_FULL:   settings.full_throttle = cfg_data.value[THR_W-1:0];
          REG_IDLE:   settings.idle_throttle = cfg_data.value[THR_W-1:0];
          REG_ENGAGE: settings.engage_speed = cfg_data.value[VEL_W-1:0];
          default: ;
        endcase
      end
      // sample transaction gives one prediction
      if (sample_valid && sample_ready) due_outputs.push_back(regulate_tick(sample_data));
      outstanding = due_outputs.size();
    end
  end

endmodule

>>> test/cruise_control_pd_throttle_tb.sv
// testbench top for the cruise control pd throttle block: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module cruise_control_pd_throttle_tb;
  import ccpd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 7;
  localparam int TICKS_PER_PHASE = 150;
  // indexes past the register map, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   gaps_on = 1'b1;
  int   stall_cycles = 0;
  int   ticks_sent = 0;
  int   writes_sent = 0;
  int   engage_now = 25;
  int   outstanding;
  int   checked;
  int   failures;

  ccpd_stream_if #(.payload_t(ccpd_cfg_wr_t)) cfg_ch ();
  ccpd_stream_if #(.payload_t(ccpd_in_t))     sample_ch ();
  ccpd_stream_if #(.payload_t(ccpd_out_t))    result_ch ();

  cruise_control_pd_throttle i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .sample (sample_ch),
    .result (result_ch)
  );

  ccpd_throttle_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_data     (cfg_ch.data),
    .sample_valid (sample_ch.valid),
    .sample_ready (sample_ch.ready),
    .sample_data  (sample_ch.data),
    .result_valid (result_ch.valid),
    .result_ready (result_ch.ready),
    .result_data  (result_ch.data),
    .outstanding  (outstanding),
    .checked      (checked),
    .failures     (failures)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // known inputs from time zero
  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    result_ch.ready = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    result_ch.ready = !gaps_on || ($urandom_range(99) >= 17);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((cfg_ch.valid && cfg_ch.ready) || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [VEL_W-1:0] clamp_vel(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[VEL_W-1:0];
  endfunction

  // one sample transaction, entered and left at a falling edge
  task automatic send_tick(input logic signed [VEL_W-1:0] vel, input logic eng,
                           input logic top, input logic cru, input logic gas);
    ccpd_in_t it;
    it.velocity = vel;
    it.engine_on = eng;
    it.high_gear = top;
    it.cruise_request = cru;
    it.accel_pedal = gas;
    while (gaps_on && $urandom_range(99) < 17) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.data = it;
    sample_ch.valid = 1'b1;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
  endtask

  // one register write transaction, valid left high for the caller to drop
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.data.index = idx;
    cfg_ch.data.value = value;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    writes_sent++;
  endtask

  // stop sending and let every predicted result come back
  task automatic wait_drained();
    sample_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // full register setting plus ignored writes past the map
  task automatic load_settings(input logic [15:0] kp, input logic [15:0] kd,
                               input logic [15:0] lim, input logic [15:0] full,
                               input logic [15:0] idle, input logic [15:0] engage);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_D, kd);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_FULL, full);
    write_reg(REG_IDLE, idle);
    write_reg(REG_ENGAGE, engage);
    write_reg(REG_SPARE_LO, 16'($urandom()));
    write_reg(REG_SPARE_HI, 16'($urandom()));
    cfg_ch.valid = 1'b0;
    engage_now = $signed(engage);
  endtask

  initial begin : stimulus
    int   n;
    int   len;
    int   span;
    int   base;
    int   spread;
    int   r;
    logic [15:0] eng_val;

    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed ticks on the reset register values
    send_tick(16'sd100, 1'b0, 1'b1, 1'b1, 1'b1);    // engine off holds everything
    send_tick(16'sd10, 1'b1, 1'b0, 1'b0, 1'b1);     // pedal gives full throttle
    send_tick(16'sd10, 1'b1, 1'b0, 1'b0, 1'b0);     // back to idle
    send_tick(16'sd24, 1'b1, 1'b1, 1'b1, 1'b0);     // just under engage speed
    send_tick(16'sd25, 1'b1, 1'b1, 1'b1, 1'b0);     // engage exactly at the threshold
    send_tick(16'sd20, 1'b1, 1'b1, 1'b1, 1'b0);     // below target, positive error
    send_tick(16'sh7FFF, 1'b1, 1'b1, 1'b1, 1'b0);   // far above target, clamped
    send_tick(16'sd30, 1'b1, 1'b1, 1'b1, 1'b1);     // pedal while regulating
    send_tick(16'sd0, 1'b0, 1'b1, 1'b1, 1'b0);      // engine off mid cruise
    send_tick(16'sd26, 1'b1, 1'b1, 1'b1, 1'b0);     // target still latched
    send_tick(16'sd30, 1'b1, 1'b1, 1'b0, 1'b1);     // disengage with pedal pressed
    send_tick(16'sd30, 1'b1, 1'b1, 1'b0, 1'b1);     // pedal again, no latch
    send_tick(16'sd40, 1'b1, 1'b1, 1'b1, 1'b0);     // re-engage with new target
    send_tick(16'sd50, 1'b1, 1'b0, 1'b1, 1'b0);     // not in high gear
    send_tick(16'sh8000, 1'b1, 1'b1, 1'b1, 1'b1);   // most negative velocity
    send_tick(16'sh7FFF, 1'b1, 1'b1, 1'b1, 1'b0);   // most positive velocity engages
    send_tick(16'sh8000, 1'b1, 1'b1, 1'b1, 1'b0);   // drop below engage speed
    wait_drained();

    // random phases, each on its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
        1: load_settings(16'd255, 16'd255, 16'h7FFF, 16'd255, 16'd255, 16'h8000);
        2: load_settings(16'd255, 16'd255, 16'h7FFF, 16'd255, 16'd255, 16'h7FFF);
        default: begin
          eng_val = ($urandom_range(1) == 0) ? 16'($urandom_range(600)) - 16'd100
                                             : 16'($urandom());
          load_settings(16'($urandom()), 16'($urandom()),
                        ($urandom_range(1) == 0) ? 16'($urandom_range(300)) : 16'($urandom()),
                        16'($urandom()), 16'($urandom()), eng_val);
        end
      endcase
      // one phase runs without any idling on either side
      gaps_on = (phase != 4);
      n = 0;
      while (n < TICKS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 70) begin
          // cruise episode around a base at or above the engage speed
          len = $urandom_range(20, 3);
          span = 32767 - engage_now;
          if ($urandom_range(3) == 0) base = engage_now + int'($urandom_range(span));
          else base = engage_now + int'($urandom_range(span > 300 ? 300 : span));
          case ($urandom_range(2))
            0: spread = 3;
            1: spread = 50;
            default: spread = 2000;
          endcase
          for (int k = 0; k < len; k++) begin
            send_tick(clamp_vel(base + int'($urandom_range(2 * spread)) - spread),
                      $urandom_range(29) != 0, $urandom_range(19) != 0,
                      $urandom_range(19) != 0, $urandom_range(9) == 0);
          end
          n += len;
        end else if (r < 85) begin
          // unstructured ticks
          len = $urandom_range(4, 1);
          for (int k = 0; k < len; k++) begin
            send_tick(16'($urandom()), 1'($urandom()), 1'($urandom()),
                      1'($urandom()), 1'($urandom()));
          end
          n += len;
        end else begin
          // broken requests: under engage speed or engine off
          send_tick(clamp_vel(engage_now - 1 - int'($urandom_range(100))), 1'b1, 1'b1,
                    1'b1, 1'($urandom()));
          send_tick(16'($urandom()), 1'b0, 1'b1, 1'b1, 1'($urandom()));
          n += 2;
        end
      end
      wait_drained();
    end

    gaps_on = 1'b1;
    repeat (4) @(negedge clk);
    $display("covered %0d control ticks and %0d register writes over %0d settings",
             ticks_sent, writes_sent, PHASES + 1);
    $display("%0d throttle results compared against prediction", checked);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
